// ===== hdl/mbrtu_pkg.sv =====
// shared types, constants and the crc step of the modbus rtu frame checker
package mbrtu_pkg;

	// frame limits and counter width
	localparam int MAX_FRAME = 256;
	localparam int CNT_W     = $clog2(MAX_FRAME + 2);
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 8;

	// crc-16 (reflected form)
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// function codes and the exception flag bit
	localparam logic [6:0] FN_READ_HOLDING = 7'd3;
	localparam logic [6:0] FN_READ_INPUT   = 7'd4;
	localparam logic [6:0] FN_WRITE_SINGLE = 7'd6;
	localparam logic [6:0] FN_WRITE_MULTI  = 7'd16;
	localparam int         FN_EXC_BIT      = 7;
	localparam logic [7:0] BROADCAST_ADDR  = 8'h00;
	localparam logic [7:0] FIXED_REPLY_LEN = 8'd6;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OWN_ADDRESS       = 3'd0,
		CFG_MASTER_MODE       = 3'd1,
		CFG_LINK_OPEN         = 3'd2,
		CFG_EXPECT_REPLY      = 3'd3,
		CFG_EXPECTED_ADDRESS  = 3'd4,
		CFG_EXPECTED_FUNCTION = 3'd5
	} cfg_index_t;

	// one received byte
	typedef struct packed {
		logic [7:0] rx_byte;
		logic       end_of_frame;
	} in_item_t;

	// one frame result
	typedef struct packed {
		logic       crc_ok;
		logic       too_short;
		logic       verdict;
		logic       exception_reply;
		logic       answer_locally;
		logic       forward_to_link;
		logic [6:0] word_count;
		logic [7:0] payload_length;
	} out_item_t;

	// one byte through the crc, bit by bit
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ===== hdl/modbus_rtu_frame_checker.sv =====
// modbus rtu frame checker: crc-16 check and frame verdict, one byte per cycle unless stalled
//
// Input channel (in_valid / in_stall / in_item) takes one frame byte per request,
// with end_of_frame set on the last byte, the two crc bytes included (low byte
// first). Output channel (out_valid / out_stall / out_item) gives one result per
// frame, nothing for the other bytes. The configuration port (cfg_write,
// cfg_index, cfg_data) sets the node address, modes and the expected reply.
// An accepted byte is held in the input register; from there it updates the
// frame state and, on the last byte, loads the result register as well.
// Throughput is one byte per cycle while no final byte waits on a stalled
// result, set by the single crc byte step between the input register and
// the frame state.
// Reset clears configuration to its defaults (own address 1), the frame state
// (crc 0xFFFF, byte count zero) and empties both registers.
// While the receiver stalls, the result holds; bytes inside a frame keep
// flowing, and only a final byte waits in the input register, stalling input,
// until the result register frees.
module modbus_rtu_frame_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  mbrtu_pkg::in_item_t                   in_item,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output mbrtu_pkg::out_item_t                  out_item,
	input  logic                                  cfg_write,
	input  logic [mbrtu_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mbrtu_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int CW = mbrtu_pkg::CNT_W;

	// configuration registers
	logic [7:0] own_address_q;
	logic       master_mode_q;
	logic       link_open_q;
	logic       expect_reply_q;
	logic [7:0] expected_address_q;
	logic [6:0] expected_function_q;

	// input register
	logic       valid_s1;
	logic [7:0] rx_byte_s1;
	logic       eof_s1;

	// frame state
	logic [15:0]   crc_q;
	logic [CW-1:0] cnt_q;
	logic [7:0]    addr_q;
	logic [7:0]    func_q;
	logic [7:0]    third_q;
	logic [7:0]    hold_q [2];

	// next frame state
	logic [15:0]   crc_nx;
	logic [CW-1:0] cnt_nx;
	logic [7:0]    addr_nx;
	logic [7:0]    func_nx;
	logic [7:0]    third_nx;
	logic [7:0]    hold_nx [2];

	logic                 adv_s1;
	logic                 out_free;
	logic                 in_acc;
	mbrtu_pkg::out_item_t res;

	// handshake control
	assign out_free = !out_valid || !out_stall;
	assign adv_s1   = valid_s1 && (!eof_s1 || out_free);
	assign in_stall = valid_s1 && !adv_s1;
	assign in_acc   = in_valid && !in_stall;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_address_q       <= 8'd1;
			master_mode_q       <= 1'b0;
			link_open_q         <= 1'b0;
			expect_reply_q      <= 1'b0;
			expected_address_q  <= 8'd0;
			expected_function_q <= 7'd0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				mbrtu_pkg::CFG_OWN_ADDRESS:       own_address_q       <= cfg_data;
				mbrtu_pkg::CFG_MASTER_MODE:       master_mode_q       <= cfg_data[0];
				mbrtu_pkg::CFG_LINK_OPEN:         link_open_q         <= cfg_data[0];
				mbrtu_pkg::CFG_EXPECT_REPLY:      expect_reply_q      <= cfg_data[0];
				mbrtu_pkg::CFG_EXPECTED_ADDRESS:  expected_address_q  <= cfg_data;
				mbrtu_pkg::CFG_EXPECTED_FUNCTION: expected_function_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			rx_byte_s1 <= in_item.rx_byte;
			eof_s1     <= in_item.end_of_frame;
		end
	end

	// frame state update for the byte in the input register
	always_comb begin
		crc_nx     = crc_q;
		cnt_nx     = cnt_q;
		addr_nx    = addr_q;
		func_nx    = func_q;
		third_nx   = third_q;
		hold_nx[0] = hold_q[0];
		hold_nx[1] = hold_q[1];
		if (cnt_q < CW'(mbrtu_pkg::MAX_FRAME)) begin
			unique case (cnt_q)
				CW'(0): addr_nx = rx_byte_s1;
				CW'(1): func_nx = rx_byte_s1;
				CW'(2): third_nx = rx_byte_s1;
				default: ;
			endcase
			// held bytes enter the crc once two newer bytes exist
			if (cnt_q >= CW'(2)) begin
				crc_nx = mbrtu_pkg::crc_feed(crc_q, hold_q[0]);
			end
			hold_nx[0] = hold_q[1];
			hold_nx[1] = rx_byte_s1;
			cnt_nx     = cnt_q + CW'(1);
		end else begin
			cnt_nx = CW'(mbrtu_pkg::MAX_FRAME + 1);
		end
	end

	// frame verdict from the updated state
	always_comb begin
		logic [7:0] len;
		logic [7:0] len_m1;
		logic [8:0] third_p1;
		logic [8:0] third_p3;
		logic [6:0] fn;
		logic [CW-1:0] len_w;
		res      = '0;
		len_w    = cnt_nx - CW'(2);
		len      = len_w[7:0];
		len_m1   = len - 8'd1;
		third_p1 = {1'b0, third_nx} + 9'd1;
		third_p3 = {1'b0, third_nx} + 9'd3;
		fn       = func_nx[6:0];
		if (cnt_nx > CW'(mbrtu_pkg::MAX_FRAME)) begin
			// oversize frame: all fields zero
		end else if (cnt_nx < CW'(4)) begin
			res.too_short      = 1'b1;
			res.payload_length = (cnt_nx >= CW'(2)) ? len : 8'd0;
		end else begin
			res.payload_length = len;
			res.crc_ok = (hold_nx[0] == crc_nx[7:0]) && (hold_nx[1] == crc_nx[15:8]);
			if (res.crc_ok) begin
				if (expect_reply_q) begin
					// reply to own request
					if (addr_nx == expected_address_q && fn == expected_function_q) begin
						priority if (func_nx[mbrtu_pkg::FN_EXC_BIT]) begin
							res.exception_reply = 1'b1;
							res.verdict         = 1'b1;
						end else if (fn == mbrtu_pkg::FN_READ_HOLDING ||
								fn == mbrtu_pkg::FN_READ_INPUT) begin
							if ({1'b0, len} == third_p3) begin
								res.verdict    = 1'b1;
								res.word_count = third_p1[7:1];
							end
						end else if (fn == mbrtu_pkg::FN_WRITE_SINGLE ||
								fn == mbrtu_pkg::FN_WRITE_MULTI) begin
							res.verdict = (len == mbrtu_pkg::FIXED_REPLY_LEN);
						end else begin
							res.verdict    = 1'b1;
							res.word_count = len_m1[7:1];
						end
					end
				end else begin
					// request seen as slave or for the link
					res.answer_locally = !master_mode_q && (addr_nx == own_address_q ||
						addr_nx == mbrtu_pkg::BROADCAST_ADDR);
					res.forward_to_link = link_open_q &&
						(addr_nx != own_address_q || master_mode_q);
					res.verdict = res.answer_locally || res.forward_to_link;
				end
			end
		end
	end

	// frame state registers, cleared after each final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q     <= mbrtu_pkg::CRC_INIT;
			cnt_q     <= '0;
			addr_q    <= '0;
			func_q    <= '0;
			third_q   <= '0;
			hold_q[0] <= '0;
			hold_q[1] <= '0;
		end else if (adv_s1) begin
			if (eof_s1) begin
				crc_q     <= mbrtu_pkg::CRC_INIT;
				cnt_q     <= '0;
				addr_q    <= '0;
				func_q    <= '0;
				third_q   <= '0;
				hold_q[0] <= '0;
				hold_q[1] <= '0;
			end else begin
				crc_q     <= crc_nx;
				cnt_q     <= cnt_nx;
				addr_q    <= addr_nx;
				func_q    <= func_nx;
				third_q   <= third_nx;
				hold_q[0] <= hold_nx[0];
				hold_q[1] <= hold_nx[1];
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv_s1 && eof_s1) begin
			out_valid <= 1'b1;
		end else if (out_valid && !out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && eof_s1) begin
			out_item <= res;
		end
	end

`ifndef SYNTHESIS
	// a new result only comes from a final byte
	a_result_from_eof: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(valid_s1 && eof_s1))
		else $error("result appeared without a final byte");

	// frame state restarts after a final byte
	a_frame_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && eof_s1) |=> (cnt_q == '0 && crc_q == mbrtu_pkg::CRC_INIT))
		else $error("frame state not cleared after final byte");

	// a positive verdict needs a good crc
	a_verdict_crc: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.verdict) |-> (out_item.crc_ok && !out_item.too_short))
		else $error("verdict without a valid crc");

	// a final byte never overwrites a waiting result
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> !(adv_s1 && eof_s1))
		else $error("result overwritten while stalled");
`endif

endmodule

// ===== dv/mbrtu_result_checker.sv =====
// crc helper and the result checker of the modbus rtu frame checker testbench
`timescale 1ns / 100ps

package mbrtu_tb_pkg;

	// one byte through the reflected crc-16
	function automatic logic [15:0] crc16_rtu_update(input logic [15:0] crc,
		input logic [7:0] data);
		logic [15:0] acc;
		acc = crc ^ {8'h00, data};
		repeat (8) begin
			if (acc[0]) begin
				acc = {1'b0, acc[15:1]} ^ mbrtu_pkg::CRC_POLY;
			end else begin
				acc = {1'b0, acc[15:1]};
			end
		end
		return acc;
	endfunction

endpackage

module mbrtu_result_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic                             in_stall,
	input  mbrtu_pkg::in_item_t              in_item,
	input  logic                             out_valid,
	input  logic                             out_stall,
	input  mbrtu_pkg::out_item_t             out_item,
	input  logic                             cfg_write,
	input  logic [mbrtu_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mbrtu_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                               outcomes_pending,
	output int                               mismatch_count
);

	// node settings as last written
	logic [7:0] own_addr_q;
	logic       master_q;
	logic       link_q;
	logic       reply_q;
	logic [7:0] reply_addr_q;
	logic [6:0] reply_fn_q;

	// frame being received
	logic [15:0] crc_run;
	int          byte_cnt;
	logic [7:0]  addr_b;
	logic [7:0]  func_b;
	logic [7:0]  third_b;
	logic [7:0]  hold_q [2];

	// frame outcomes still owed by the block
	mbrtu_pkg::out_item_t outcomes_due[$];
	int                   mismatches = 0;

	function automatic void clear_frame();
		crc_run  = mbrtu_pkg::CRC_INIT;
		byte_cnt = 0;
		addr_b   = '0;
		func_b   = '0;
		third_b  = '0;
		hold_q[0] = '0;
		hold_q[1] = '0;
	endfunction

	// one accepted byte; on the last byte of a frame, the outcome it owes
	task automatic absorb_frame_byte(input mbrtu_pkg::in_item_t item);
		mbrtu_pkg::out_item_t r;
		int                   len;
		logic [6:0]           fn7;
		if (byte_cnt < mbrtu_pkg::MAX_FRAME) begin
			case (byte_cnt)
				0: addr_b = item.rx_byte;
				1: func_b = item.rx_byte;
				2: third_b = item.rx_byte;
				default: ;
			endcase
			// the two newest bytes are held back as the crc candidate
			if (byte_cnt >= 2) begin
				crc_run = mbrtu_tb_pkg::crc16_rtu_update(crc_run, hold_q[0]);
			end
			hold_q[0] = hold_q[1];
			hold_q[1] = item.rx_byte;
			byte_cnt++;
		end else begin
			byte_cnt = mbrtu_pkg::MAX_FRAME + 1;
		end
		if (!item.end_of_frame) begin
			return;
		end
		r = '0;
		if (byte_cnt > mbrtu_pkg::MAX_FRAME) begin
			// oversize frame: every field stays zero
		end else if (byte_cnt < 4) begin
			r.too_short = 1'b1;
			r.payload_length = (byte_cnt >= 2) ? 8'(byte_cnt - 2) : 8'd0;
		end else begin
			len = byte_cnt - 2;
			r.payload_length = 8'(len);
			r.crc_ok = (hold_q[0] == crc_run[7:0]) && (hold_q[1] == crc_run[15:8]);
			if (r.crc_ok && reply_q) begin
				// reply to our own request: match, then length by function
				fn7 = func_b[6:0];
				if (addr_b == reply_addr_q && fn7 == reply_fn_q) begin
					if (func_b[mbrtu_pkg::FN_EXC_BIT]) begin
						r.exception_reply = 1'b1;
						r.verdict = 1'b1;
					end else if (fn7 == mbrtu_pkg::FN_READ_HOLDING ||
							fn7 == mbrtu_pkg::FN_READ_INPUT) begin
						if (len == int'(third_b) + 3) begin
							r.verdict = 1'b1;
							r.word_count = 7'((int'(third_b) + 1) >> 1);
						end
					end else if (fn7 == mbrtu_pkg::FN_WRITE_SINGLE ||
							fn7 == mbrtu_pkg::FN_WRITE_MULTI) begin
						r.verdict = (len == int'(mbrtu_pkg::FIXED_REPLY_LEN));
					end else begin
						r.verdict = 1'b1;
						r.word_count = 7'((len - 1) >> 1);
					end
				end
			end else if (r.crc_ok) begin
				// request on the bus: answer here and/or pass to the link
				r.answer_locally = !master_q &&
					(addr_b == own_addr_q || addr_b == mbrtu_pkg::BROADCAST_ADDR);
				r.forward_to_link = link_q && (addr_b != own_addr_q || master_q);
				r.verdict = r.answer_locally || r.forward_to_link;
			end
		end
		outcomes_due.push_back(r);
		clear_frame();
	endtask

	task automatic check_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// watch config writes, results and requests
	always @(posedge clk) begin
		mbrtu_pkg::out_item_t want;
		if (!arst_n) begin
			own_addr_q   = 8'd1;
			master_q     = 1'b0;
			link_q       = 1'b0;
			reply_q      = 1'b0;
			reply_addr_q = '0;
			reply_fn_q   = '0;
			clear_frame();
			outcomes_due.delete();
		end else begin
			if (cfg_write) begin
				unique case (mbrtu_pkg::cfg_index_t'(cfg_index))
					mbrtu_pkg::CFG_OWN_ADDRESS:       own_addr_q = cfg_data;
					mbrtu_pkg::CFG_MASTER_MODE:       master_q = cfg_data[0];
					mbrtu_pkg::CFG_LINK_OPEN:         link_q = cfg_data[0];
					mbrtu_pkg::CFG_EXPECT_REPLY:      reply_q = cfg_data[0];
					mbrtu_pkg::CFG_EXPECTED_ADDRESS:  reply_addr_q = cfg_data;
					mbrtu_pkg::CFG_EXPECTED_FUNCTION: reply_fn_q = cfg_data[6:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (outcomes_due.size() == 0) begin
					$error("result with no frame waiting: %h", out_item);
					mismatches++;
				end else begin
					want = outcomes_due.pop_front();
					check_field("crc_ok", 8'(want.crc_ok), 8'(out_item.crc_ok));
					check_field("too_short", 8'(want.too_short),
						8'(out_item.too_short));
					check_field("verdict", 8'(want.verdict), 8'(out_item.verdict));
					check_field("exception_reply", 8'(want.exception_reply),
						8'(out_item.exception_reply));
					check_field("answer_locally", 8'(want.answer_locally),
						8'(out_item.answer_locally));
					check_field("forward_to_link", 8'(want.forward_to_link),
						8'(out_item.forward_to_link));
					check_field("word_count", 8'(want.word_count),
						8'(out_item.word_count));
					check_field("payload_length", want.payload_length,
						out_item.payload_length);
				end
			end
			if (in_valid && !in_stall) begin
				absorb_frame_byte(in_item);
			end
		end
		outcomes_pending <= outcomes_due.size();
		mismatch_count <= mismatches;
	end

endmodule

// ===== dv/tb_top.sv =====
// testbench top: clock, reset, frame stimulus, settings phases and the verdict
`timescale 1ns / 100ps

module tb_top;

	localparam int RAND_BYTES   = 650;
	localparam int DRAIN_CYCLES = 4;

	logic                             clk;
	logic                             arst_n;
	logic                             in_valid;
	logic                             in_stall;
	mbrtu_pkg::in_item_t              in_item;
	logic                             out_valid;
	logic                             out_stall;
	mbrtu_pkg::out_item_t             out_item;
	logic                             cfg_write;
	logic [mbrtu_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [mbrtu_pkg::CFG_DATA_W-1:0] cfg_data;
	int                               outcomes_pending;
	int                               mismatch_count;

	// settings as last written, used to aim frames at the block
	logic [7:0] own_addr;
	logic       master_on;
	logic       link_on;
	logic       reply_wait;
	logic [7:0] reply_addr;
	logic [6:0] reply_fn;

	int         bytes_sent;
	bit         quiet_stretch;
	logic [7:0] frame_q[$];

	modbus_rtu_frame_checker uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	mbrtu_result_checker result_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.in_item          (in_item),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.out_item         (out_item),
		.cfg_write        (cfg_write),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.outcomes_pending (outcomes_pending),
		.mismatch_count   (mismatch_count)
	);

	// 2 ns clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// hard stop for a hung run
	initial begin
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end

	// result side stalls: free runs, random chatter and long holds
	initial begin
		int run;
		int mode;
		out_stall <= 1'b0;
		forever begin
			mode = $urandom_range(0, 9);
			run = $urandom_range(10, 60);
			repeat (run) begin
				@(posedge clk);
				if (mode < 3) begin
					out_stall <= 1'b0;
				end else if (mode == 9) begin
					out_stall <= 1'b1;
				end else begin
					out_stall <= ($urandom_range(0, 99) < 35);
				end
			end
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int idle_gap();
		int r;
		if (quiet_stretch) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end
		if (r < 90) begin
			return $urandom_range(1, 3);
		end
		if (r < 98) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic eof);
		int gap;
		in_item <= '{rx_byte: b, end_of_frame: eof};
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		bytes_sent++;
		gap = idle_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_frame();
		for (int i = 0; i < frame_q.size(); i++) begin
			send_byte(frame_q[i], i == frame_q.size() - 1);
		end
	endtask

	// crc low byte first, then high byte
	task automatic append_crc();
		logic [15:0] c;
		c = mbrtu_pkg::CRC_INIT;
		foreach (frame_q[i]) begin
			c = mbrtu_tb_pkg::crc16_rtu_update(c, frame_q[i]);
		end
		frame_q.push_back(c[7:0]);
		frame_q.push_back(c[15:8]);
	endtask

	// wait until every result is in and the pipeline has drained
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (outcomes_pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_address();
		case ($urandom_range(0, 5))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'h01;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [6:0] pick_function();
		case ($urandom_range(0, 7))
			0: return mbrtu_pkg::FN_READ_HOLDING;
			1: return mbrtu_pkg::FN_READ_INPUT;
			2: return mbrtu_pkg::FN_WRITE_SINGLE;
			3: return mbrtu_pkg::FN_WRITE_MULTI;
			4: return 7'h00;
			5: return 7'h7F;
			default: return 7'($urandom);
		endcase
	endfunction

	// mostly well-formed frames aimed at the current settings, some noise
	task automatic build_random_frame();
		int         r;
		int         n;
		int         fn_pick;
		logic [7:0] addr;
		logic [7:0] fn;
		logic [7:0] count;
		frame_q.delete();
		r = $urandom_range(0, 99);
		if (r < 6) begin
			// short frame
			repeat ($urandom_range(1, 3)) frame_q.push_back(8'($urandom));
			return;
		end
		if (r < 12) begin
			// line noise
			repeat ($urandom_range(4, 14)) frame_q.push_back(8'($urandom));
			return;
		end
		// address
		if (reply_wait) begin
			addr = ($urandom_range(0, 3) != 0) ? reply_addr : 8'($urandom);
		end else begin
			case ($urandom_range(0, 6))
				0, 1: addr = own_addr;
				2: addr = mbrtu_pkg::BROADCAST_ADDR;
				default: addr = 8'($urandom);
			endcase
		end
		// function, with exception replies now and then
		fn_pick = $urandom_range(0, 9);
		if (reply_wait && fn_pick < 5) begin
			fn = {1'b0, reply_fn};
		end else if (reply_wait && fn_pick < 7) begin
			fn = {1'b1, reply_fn};
		end else begin
			fn = {($urandom_range(0, 9) == 0), pick_function()};
		end
		frame_q.push_back(addr);
		frame_q.push_back(fn);
		// data bytes, mostly of the length the function calls for
		if (fn[mbrtu_pkg::FN_EXC_BIT]) begin
			n = $urandom_range(0, 2);
		end else if (fn[6:0] == mbrtu_pkg::FN_READ_HOLDING ||
				fn[6:0] == mbrtu_pkg::FN_READ_INPUT) begin
			if ($urandom_range(0, 4) != 0) begin
				count = 8'($urandom_range(0, 20));
				n = int'(count);
			end else begin
				count = 8'($urandom);
				n = $urandom_range(0, 10);
			end
			frame_q.push_back(count);
		end else if (fn[6:0] == mbrtu_pkg::FN_WRITE_SINGLE ||
				fn[6:0] == mbrtu_pkg::FN_WRITE_MULTI) begin
			n = ($urandom_range(0, 4) != 0) ? 4 : $urandom_range(0, 9);
		end else begin
			n = $urandom_range(0, 10);
		end
		repeat (n) frame_q.push_back(8'($urandom));
		append_crc();
		// one flipped bit anywhere, crc bytes included
		if (r < 22) begin
			n = $urandom_range(0, frame_q.size() - 1);
			frame_q[n] = frame_q[n] ^ 8'(1 << $urandom_range(0, 7));
		end
	endtask

	// main stimulus
	initial begin
		int phase;
		int frames;
		int start_count;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		in_item   <= '0;
		cfg_write <= 1'b0;
		cfg_index <= mbrtu_pkg::CFG_OWN_ADDRESS;
		cfg_data  <= '0;
		own_addr      = 8'd1;
		master_on     = 1'b0;
		link_on       = 1'b0;
		reply_wait    = 1'b0;
		reply_addr    = '0;
		reply_fn      = '0;
		quiet_stretch = 1'b0;
		bytes_sent    = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// short frames of one, two and three bytes
		frame_q = {8'hFF};
		send_frame();
		frame_q = {8'h00, 8'h00};
		send_frame();
		frame_q = {8'h01, 8'h03, 8'hFF};
		send_frame();
		// minimal frame to this node, broadcast, other slave with no link
		frame_q = {8'h01, 8'h00};
		append_crc();
		send_frame();
		frame_q = {8'h00, 8'hFF, 8'h00};
		append_crc();
		send_frame();
		frame_q = {8'hFF, 8'h11};
		append_crc();
		send_frame();
		// broken crc high byte
		frame_q = {8'h01, 8'h03};
		append_crc();
		frame_q[3] = ~frame_q[3];
		send_frame();

		// random phases, each under its own settings
		start_count = bytes_sent;
		phase = 0;
		while (bytes_sent - start_count < RAND_BYTES) begin
			settle();
			case (phase)
				0: begin
					own_addr = 8'h00; master_on = 1'b0; link_on = 1'b1;
					reply_wait = 1'b0; reply_addr = 8'h00; reply_fn = 7'h00;
				end
				1: begin
					own_addr = 8'hFF; master_on = 1'b0; link_on = 1'b0;
					reply_wait = 1'b1; reply_addr = 8'hFF;
					reply_fn = mbrtu_pkg::FN_READ_HOLDING;
				end
				2: begin
					own_addr = 8'h01; master_on = 1'b1; link_on = 1'b1;
					reply_wait = 1'b1; reply_addr = 8'h00; reply_fn = 7'h7F;
				end
				default: begin
					own_addr   = pick_address();
					master_on  = 1'($urandom_range(0, 1));
					link_on    = 1'($urandom_range(0, 1));
					reply_wait = 1'($urandom_range(0, 1));
					reply_addr = pick_address();
					reply_fn   = pick_function();
				end
			endcase
			cfg_write <= 1'b1;
			cfg_index <= mbrtu_pkg::CFG_OWN_ADDRESS;
			cfg_data  <= own_addr;
			@(posedge clk);
			cfg_index <= mbrtu_pkg::CFG_MASTER_MODE;
			cfg_data  <= {7'd0, master_on};
			@(posedge clk);
			cfg_index <= mbrtu_pkg::CFG_LINK_OPEN;
			cfg_data  <= {7'd0, link_on};
			@(posedge clk);
			cfg_index <= mbrtu_pkg::CFG_EXPECT_REPLY;
			cfg_data  <= {7'd0, reply_wait};
			@(posedge clk);
			cfg_index <= mbrtu_pkg::CFG_EXPECTED_ADDRESS;
			cfg_data  <= reply_addr;
			@(posedge clk);
			cfg_index <= mbrtu_pkg::CFG_EXPECTED_FUNCTION;
			cfg_data  <= {1'b0, reply_fn};
			@(posedge clk);
			cfg_write <= 1'b0;

			frames = $urandom_range(4, 10);
			for (int f = 0; f < frames; f++) begin
				quiet_stretch = ($urandom_range(0, 5) == 0);
				if (phase == 1 && f == 0) begin
					// longest frame taken: read reply with 251 data bytes
					frame_q = {reply_addr, 8'(mbrtu_pkg::FN_READ_HOLDING), 8'd251};
					repeat (251) frame_q.push_back(8'($urandom));
					append_crc();
				end else if (phase == 3 && f == 0) begin
					// frame past the size limit
					frame_q.delete();
					repeat ($urandom_range(257, 270)) frame_q.push_back(8'($urandom));
				end else begin
					build_random_frame();
				end
				send_frame();
			end
			quiet_stretch = 1'b0;
			phase++;
		end

		settle();
		if (mismatch_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
